### rtl/u8f_pkg.sv
// ----------------------------------------------------------------------------
// UTF-8 filter package
// Shared constants and types for the UTF-8 malformed sequence filter.
// ----------------------------------------------------------------------------
package u8f_pkg;

    // Byte classes.
    localparam logic [7:0] C_CONT_MASK = 8'hC0;
    localparam logic [7:0] C_CONT_CODE = 8'h80;
    localparam logic [7:0] C_LEAD_MIN  = 8'hC0;
    localparam logic [7:0] C_LEAD3_MIN = 8'hE0;
    localparam logic [7:0] C_LEAD4_MIN = 8'hF0;

    // Continuation bytes still awaited after a lead byte.
    localparam logic [1:0] C_NEED_2B = 2'd1;
    localparam logic [1:0] C_NEED_3B = 2'd2;
    localparam logic [1:0] C_NEED_4B = 2'd3;

    // Largest number of bytes one request can release.
    localparam int         MAX_PUSH = 4;

    // Output queue geometry.
    localparam int         QDEPTH   = 8;
    localparam int         QCNT_W   = $clog2(QDEPTH + 1);
    localparam logic [QCNT_W-1:0] C_Q_FULL  = QCNT_W'(QDEPTH);
    localparam logic [QCNT_W-1:0] C_Q_ROOM  = QCNT_W'(QDEPTH - MAX_PUSH);

    // Bytes released toward the output queue in one cycle.
    typedef struct packed {
        logic [2:0]                 n;
        logic [MAX_PUSH-1:0][7:0]   data;
        logic [MAX_PUSH-1:0]        last;
    } t_push;

endpackage

### rtl/u8f_decode.sv
// ----------------------------------------------------------------------------
// UTF-8 sequence decoder
// Registers one input byte, tracks the open sequence and releases the
// bytes of each complete character in one step.
// ----------------------------------------------------------------------------
module u8f_decode (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic [7:0]      i_byte,
    output logic            o_ready,
    input  logic            i_space_ok,
    output u8f_pkg::t_push  o_push
);

    logic            r_in_valid;
    logic [7:0]      r_in_byte;
    logic [1:0]      r_need;
    logic [1:0]      r_held_cnt;
    logic [2:0][7:0] r_held;

    logic            n_in_valid;
    logic [1:0]      n_need;
    logic [1:0]      n_held_cnt;

    logic            fire;
    logic            is_cont;
    logic            is_ascii;
    logic            is_lead;
    logic            emit;
    logic            hold_cont;

    // The staged byte moves on once the queue has room for a full character.
    assign fire    = r_in_valid && i_space_ok;
    assign o_ready = !r_in_valid || i_space_ok;

    // Byte classification.
    assign is_cont  = (r_in_byte & u8f_pkg::C_CONT_MASK) == u8f_pkg::C_CONT_CODE;
    assign is_ascii = !r_in_byte[7];
    assign is_lead  = r_in_byte >= u8f_pkg::C_LEAD_MIN;

    // A character completes on its final continuation byte or on ASCII outside
    // a sequence. The held count is zero whenever no sequence is open.
    assign emit      = fire && (((r_need == 2'd1) && is_cont) ||
                                ((r_need == 2'd0) && is_ascii));
    assign hold_cont = fire && (r_need > 2'd1) && is_cont;

    // Sequence state update.
    always_comb begin
        n_need     = r_need;
        n_held_cnt = r_held_cnt;
        if (fire) begin
            if (r_need != 2'd0) begin
                if (!is_cont || (r_need == 2'd1)) begin
                    n_need     = 2'd0;
                    n_held_cnt = 2'd0;
                end else begin
                    n_need     = r_need - 2'd1;
                    n_held_cnt = r_held_cnt + 2'd1;
                end
            end else if (is_lead) begin
                n_held_cnt = 2'd1;
                if (r_in_byte >= u8f_pkg::C_LEAD4_MIN) begin
                    n_need = u8f_pkg::C_NEED_4B;
                end else if (r_in_byte >= u8f_pkg::C_LEAD3_MIN) begin
                    n_need = u8f_pkg::C_NEED_3B;
                end else begin
                    n_need = u8f_pkg::C_NEED_2B;
                end
            end
        end
    end

    // Released bytes: the held ones first, then the current byte marked last.
    always_comb begin
        o_push.n = emit ? ({1'b0, r_held_cnt} + 3'd1) : 3'd0;
        for (int k = 0; k < u8f_pkg::MAX_PUSH; k++) begin
            if (k < 3 && 2'(k) < r_held_cnt) begin
                o_push.data[k] = r_held[k < 3 ? k : 0];
                o_push.last[k] = 1'b0;
            end else begin
                o_push.data[k] = r_in_byte;
                o_push.last[k] = 1'b1;
            end
        end
    end

    assign n_in_valid = o_ready ? i_valid : r_in_valid;

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_need     <= 2'd0;
            r_held_cnt <= 2'd0;
        end else begin
            r_in_valid <= n_in_valid;
            r_need     <= n_need;
            r_held_cnt <= n_held_cnt;
        end
    end

    // Input byte and held bytes.
    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_in_byte <= i_byte;
        end
        if (fire && (r_need == 2'd0) && is_lead) begin
            r_held[0] <= r_in_byte;
        end
        for (int i = 0; i < 3; i++) begin
            if (hold_cont && (r_held_cnt == 2'(i))) begin
                r_held[i] <= r_in_byte;
            end
        end
    end

    // An open sequence always holds its lead byte.
    a_open_holds_lead: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_need != 2'd0) |-> (r_held_cnt != 2'd0))
        else $error("open sequence with no held byte");

    // With no open sequence nothing is held.
    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_need == 2'd0) |-> (r_held_cnt == 2'd0))
        else $error("held bytes without an open sequence");

    // A character never spans more than four bytes.
    a_seq_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_need} + {1'b0, r_held_cnt}) <= 3'd4)
        else $error("sequence length out of range");

endmodule

### rtl/u8f_outq.sv
// ----------------------------------------------------------------------------
// UTF-8 filter output queue
// Shift queue that takes up to four bytes a cycle and sends one a cycle while i_ready is high.
// ----------------------------------------------------------------------------
module u8f_outq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  u8f_pkg::t_push  i_push,
    output logic            o_space_ok,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [7:0]      o_data,
    output logic            o_last
);

    logic [u8f_pkg::QDEPTH-1:0][7:0]  r_q_data;
    logic [u8f_pkg::QDEPTH-1:0]       r_q_last;
    logic [u8f_pkg::QCNT_W-1:0]       r_cnt;

    logic [u8f_pkg::QDEPTH-1:0][7:0]  n_q_data;
    logic [u8f_pkg::QDEPTH-1:0]       n_q_last;
    logic [u8f_pkg::QCNT_W-1:0]       n_cnt;

    logic                             pop;
    logic [u8f_pkg::QCNT_W-1:0]       base;
    logic [u8f_pkg::QCNT_W-1:0]       offs;

    assign o_valid    = r_cnt != '0;
    assign o_data     = r_q_data[0];
    assign o_last     = r_q_last[0];
    assign pop        = o_valid && i_ready;
    assign o_space_ok = r_cnt <= u8f_pkg::C_Q_ROOM;

    assign base  = r_cnt - u8f_pkg::QCNT_W'(pop);
    assign n_cnt = base + u8f_pkg::QCNT_W'(i_push.n);

    // Shift out the sent byte, then append the new ones after the survivors.
    always_comb begin
        for (int i = 0; i < u8f_pkg::QDEPTH; i++) begin
            offs = u8f_pkg::QCNT_W'(i) - base;
            if (pop && (i < u8f_pkg::QDEPTH - 1)) begin
                n_q_data[i] = r_q_data[(i < u8f_pkg::QDEPTH - 1) ? i + 1 : i];
                n_q_last[i] = r_q_last[(i < u8f_pkg::QDEPTH - 1) ? i + 1 : i];
            end else begin
                n_q_data[i] = r_q_data[i];
                n_q_last[i] = r_q_last[i];
            end
            if ((u8f_pkg::QCNT_W'(i) >= base) &&
                (offs < u8f_pkg::QCNT_W'(i_push.n))) begin
                n_q_data[i] = i_push.data[offs[1:0]];
                n_q_last[i] = i_push.last[offs[1:0]];
            end
        end
    end

    // Fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    // Queue entries.
    always_ff @(posedge i_clk) begin
        r_q_data <= n_q_data;
        r_q_last <= n_q_last;
    end

    // The queue never overfills.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= u8f_pkg::C_Q_FULL)
        else $error("output queue overflow");

    // Bytes only arrive when room for a whole character was reported.
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.n != 3'd0) |-> o_space_ok)
        else $error("push without room");

    // The count moves by exactly the pushed bytes less the sent one.
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(!i_rst_n) |-> (r_cnt == $past(r_cnt) + $past(u8f_pkg::QCNT_W'(i_push.n))
                              - $past(u8f_pkg::QCNT_W'(pop))))
        else $error("queue count mismatch");

endmodule

### rtl/utf8_malformed_sequence_filter_unit.sv
// ----------------------------------------------------------------------------
// UTF-8 malformed sequence filter
// Passes only structurally complete UTF-8 characters from a byte stream;
// bytes of a multi-byte character are released together when it completes.
//
//   channel   | dir | content
//   s_axis    | in  | tdata[7:0] = in_byte
//   m_axis    | out | tdata[7:0] = out_byte, tlast = char_end
//
// One byte is accepted per cycle while the input is not stalled; the byte
// is registered and decoded from the register, and its released bytes
// leave from an eight-entry queue one per cycle while m_axis is ready.
// Input stalls only when the queue holds more than four bytes; a sustained
// rate of one byte per cycle holds while m_axis is ready, since a character
// never releases more bytes than it took in; the queue drains as it fills.
// Reset is synchronous, active low, and closes any open sequence.
// ----------------------------------------------------------------------------
module utf8_malformed_sequence_filter_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] in_byte
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // [7:0] out_byte
    output logic       o_m_axis_tlast
);

    u8f_pkg::t_push push;
    logic           space_ok;

    // Sequence tracking.
    u8f_decode u_decode (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_s_axis_tvalid),
        .i_byte     (i_s_axis_tdata),
        .o_ready    (o_s_axis_tready),
        .i_space_ok (space_ok),
        .o_push     (push)
    );

    // Output queue.
    u8f_outq u_outq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .o_space_ok (space_ok),
        .o_valid    (o_m_axis_tvalid),
        .i_ready    (i_m_axis_tready),
        .o_data     (o_m_axis_tdata),
        .o_last     (o_m_axis_tlast)
    );

endmodule
